@@ hdl/fchc_pkg.sv @@
// Shared types, constants and the CRC-32C folding matrix for the filename hash block.
package fchc_pkg;

    localparam int CP_W   = 21;
    localparam int LEN_W  = 10;
    localparam int CRC_W  = 32;
    localparam int HASH_W = 32;
    localparam int HASH_BITS = HASH_W - LEN_W;

    localparam logic [CRC_W-1:0] CRC_INIT   = 32'hFFFF_FFFF;
    localparam logic [CRC_W-1:0] CRC_POLY_R = 32'h82F6_3B78;

    typedef logic [CRC_W-1:0][CRC_W-1:0] t_crc_mat;

    // One word held in the input stage.
    typedef struct packed {
        logic             valid;
        logic [CP_W-1:0]  code_point;
        logic [LEN_W-1:0] name_length;
    } t_item;

    // Row i: the CRC after 32 reflected shift steps starting from bit i alone.
    function automatic t_crc_mat crc_matrix();
        t_crc_mat         m;
        logic [CRC_W-1:0] c;
        for (int i = 0; i < CRC_W; i++) begin
            c = '0;
            c[i] = 1'b1;
            for (int s = 0; s < CRC_W; s++) begin
                c = c[0] ? ((c >> 1) ^ CRC_POLY_R) : (c >> 1);
            end
            m[i] = c;
        end
        return m;
    endfunction

    localparam t_crc_mat CRC_MAT = crc_matrix();

endpackage

@@ hdl/fchc_in_reg.sv @@
// Input register stage: capture one word, hold it until the CRC stage drains it.
module fchc_in_reg
    import fchc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [CP_W-1:0]  i_code_point,
    input  logic [LEN_W-1:0] i_name_length,
    input  logic             i_drain,
    output logic             o_stall,
    output t_item            o_item
);

    logic             r_valid;
    logic [CP_W-1:0]  r_code_point;
    logic [LEN_W-1:0] r_name_length;
    logic             w_accept;

    assign o_stall  = r_valid && !i_drain;
    assign w_accept = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_code_point  <= i_code_point;
            r_name_length <= i_name_length;
        end
    end

    assign o_item = '{valid: r_valid, code_point: r_code_point, name_length: r_name_length};

endmodule

@@ hdl/fchc_crc_core.sv @@
// Running CRC-32C register, one-word fold and the result register.
module fchc_crc_core
    import fchc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_item             i_item,
    input  logic              i_out_stall,
    output logic              o_drain,
    output logic              o_valid,
    output logic [HASH_W-1:0] o_key_hash
);

    logic [CRC_W-1:0]  r_crc;
    logic [CRC_W-1:0]  n_crc;
    logic              r_out_valid;
    logic [HASH_W-1:0] r_key_hash;
    logic [CRC_W-1:0]  w_data;
    logic [CRC_W-1:0]  w_fold;
    logic [LEN_W-1:0]  w_len_p1;
    logic              w_is_end;
    logic              w_out_free;
    logic              w_fire;

    assign w_is_end   = (i_item.code_point == '0);
    assign w_out_free = !r_out_valid || !i_out_stall;
    // A code point never waits on the output; only an end word does.
    assign o_drain    = !w_is_end || w_out_free;
    assign w_fire     = i_item.valid && o_drain;
    assign w_len_p1   = i_item.name_length + LEN_W'(1);

    // Four reflected byte steps collapse to one linear map of crc ^ word.
    assign w_data = r_crc ^ CRC_W'(i_item.code_point);
    always_comb begin
        w_fold = '0;
        for (int i = 0; i < CRC_W; i++) begin
            if (w_data[i]) begin
                w_fold = w_fold ^ CRC_MAT[i];
            end
        end
    end

    always_comb begin
        n_crc = r_crc;
        if (w_fire) begin
            n_crc = w_is_end ? CRC_INIT : w_fold;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc       <= CRC_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_crc <= n_crc;
            if (w_out_free) begin
                r_out_valid <= w_fire && w_is_end;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_is_end) begin
            r_key_hash <= {r_crc[HASH_BITS-1:0], w_len_p1};
        end
    end

    assign o_valid    = r_out_valid;
    assign o_key_hash = r_key_hash;

endmodule

@@ hdl/filename_hash_crc32c_top.sv @@
// Top level of the filename hash block: input stage, CRC stage, result register.
// The key of an end word is computed from the input register and captured in the result register.
// Throughput: one word per cycle unless stalled; the CRC-32C fold of a whole code point is
//   one XOR matrix between the input register and the running CRC register.
// Only an end word with the result register full and stalled holds the input.
// Reset: synchronous, active low; clears both valid flags and loads the CRC with all ones.
module filename_hash_crc32c_top
    import fchc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [CP_W-1:0]   i_code_point,
    input  logic [LEN_W-1:0]  i_name_length,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [HASH_W-1:0] o_key_hash
);

    t_item w_item;
    logic  w_drain;
    logic  w_end_fire;

    // Hold the incoming word; advance it whenever the CRC stage can take it.
    fchc_in_reg u_in_reg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_in_valid),
        .i_code_point  (i_code_point),
        .i_name_length (i_name_length),
        .i_drain       (w_drain),
        .o_stall       (o_in_stall),
        .o_item        (w_item)
    );

    // Fold code points into the running CRC; drop a result on each end word.
    fchc_crc_core u_crc_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (w_item),
        .i_out_stall (i_out_stall),
        .o_drain     (w_drain),
        .o_valid     (o_out_valid),
        .o_key_hash  (o_key_hash)
    );

    assign w_end_fire = w_item.valid && w_drain && (w_item.code_point == '0);

`ifndef ASSERT_OFF
    // Input is held back only by a full, stalled result register.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without output backpressure");

    // A new result appears only after an end word left the input stage.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_end_fire))
        else $error("result without end word");

    // Length bits of the result are the end word's length plus one.
    a_len_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_end_fire |=> (o_key_hash[LEN_W-1:0] == ($past(w_item.name_length) + LEN_W'(1))))
        else $error("length field mismatch");
`endif

endmodule

@@ bench/filename_hash_crc32c_top_tb.sv @@
// Self-checking testbench for the CRC-32C filename hash block.
`timescale 1ns / 1ps

module filename_hash_crc32c_top_tb
    import fchc_pkg::*;
;

    localparam int  RAND_WORDS = 550;
    localparam int  PHASES     = 4;
    // Well above the slowest legal run, even with the heaviest stall pattern.
    localparam time RUN_LIMIT  = 2_000_000ns;

    // One row of the directed table. Where typed is set, hash is the expected
    // key for an end word, read straight off the spec.
    typedef struct packed {
        logic [CP_W-1:0]   cp;
        logic [LEN_W-1:0]  len;
        logic              typed;
        logic [HASH_W-1:0] hash;
    } t_dir_row;

    localparam int DIR_ROWS = 19;
    localparam t_dir_row DIRECTED [DIR_ROWS] = '{
        // empty name right after reset: all-ones CRC, length 0 -> 1
        '{21'h000000, 10'd0,    1'b1, 32'hFFFF_FC01},
        // empty name with the longest length: length plus one wraps to zero
        '{21'h000000, 10'd1023, 1'b1, 32'hFFFF_FC00},
        // empty name, all key bits set
        '{21'h000000, 10'd1022, 1'b1, 32'hFFFF_FFFF},
        // all ones in the code point, above the Unicode range; length ignored
        '{21'h1FFFFF, 10'd0,    1'b0, 32'h0},
        '{21'h000001, 10'd1023, 1'b0, 32'h0},
        '{21'h000000, 10'd4,    1'b0, 32'h0},
        '{21'h10FFFF, 10'd0,    1'b0, 32'h0},
        '{21'h100000, 10'd513,  1'b0, 32'h0},
        '{21'h0AAAAA, 10'd682,  1'b0, 32'h0},
        '{21'h155555, 10'd341,  1'b0, 32'h0},
        '{21'h000000, 10'd16,   1'b0, 32'h0},
        '{21'h000041, 10'd0,    1'b0, 32'h0},
        '{21'h000042, 10'd0,    1'b0, 32'h0},
        '{21'h000043, 10'd0,    1'b0, 32'h0},
        '{21'h000000, 10'd3,    1'b0, 32'h0},
        // back-to-back end words: second name is empty
        '{21'h000000, 10'd512,  1'b1, 32'hFFFF_FE01},
        '{21'h110000, 10'd7,    1'b0, 32'h0},
        '{21'h000000, 10'd1023, 1'b0, 32'h0},
        '{21'h000000, 10'd0,    1'b1, 32'hFFFF_FC01}
    };

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    logic [CP_W-1:0]   i_code_point;
    logic [LEN_W-1:0]  i_name_length;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic [HASH_W-1:0] o_key_hash;

    // Typed expectation, driven alongside the payload so it is sampled with it.
    logic              typed_on;
    logic [HASH_W-1:0] typed_hash;

    // Model state and scoreboard.
    logic [CRC_W-1:0]  name_crc = CRC_INIT;
    logic [HASH_W-1:0] pending_hashes [$];
    int                mismatches    = 0;
    int                words_taken   = 0;
    int                hashes_seen   = 0;
    int                names_sent    = 0;

    // Traffic shaping knobs, changed per phase.
    bit                sender_gaps   = 1'b0;
    int                stall_level   = 0;
    int                burst_left    = 0;
    logic [15:0]       stall_pat     = '0;
    logic [5:0]        stall_tick    = '0;

    filename_hash_crc32c_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_code_point  (i_code_point),
        .i_name_length (i_name_length),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_key_hash    (o_key_hash)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Fold the 32-bit zero-extended code point into the CRC, one bit at a time,
    // low bit first. Bitwise reflected form is the same as the byte-wise one.
    function automatic logic [CRC_W-1:0] crc32c_fold(input logic [CRC_W-1:0] crc,
                                                     input logic [CP_W-1:0]  cp);
        logic [CRC_W-1:0] word;
        logic             fb;
        word = CRC_W'(cp);
        for (int i = 0; i < CRC_W; i++) begin
            fb  = crc[0] ^ word[i];
            crc = crc >> 1;
            if (fb) begin
                crc = crc ^ CRC_POLY_R;
            end
        end
        return crc;
    endfunction

    // Pick a nonzero code point: mostly ASCII and BMP, some supplementary,
    // and a few out-of-range values that still fit the 21-bit field.
    function automatic logic [CP_W-1:0] pick_code_point();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return CP_W'($urandom_range(32'h20, 32'h7E));
            4, 5:       return CP_W'($urandom_range(32'h80, 32'hFFFF));
            6, 7:       return CP_W'($urandom_range(32'h1, 32'h10FFFF));
            8:          return CP_W'($urandom_range(32'h10000, 32'h10FFFF));
            default:    return CP_W'($urandom_range(32'h1, 32'h1FFFFF));
        endcase
    endfunction

    // Present one word and hold it until the block takes it. Between bursts,
    // with sender gaps on, drop valid and scramble the idle payload.
    task automatic send_word(input logic [CP_W-1:0]   cp,
                             input logic [LEN_W-1:0]  len,
                             input logic              typed,
                             input logic [HASH_W-1:0] hash);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = sender_gaps ? $urandom_range(1, 8) : 0;
            if (gap > 0) begin
                i_in_valid    <= 1'b0;
                i_code_point  <= CP_W'($urandom);
                i_name_length <= LEN_W'($urandom);
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid    <= 1'b1;
        i_code_point  <= cp;
        i_name_length <= len;
        typed_on      <= typed;
        typed_hash    <= hash;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Send one random name: its code points, then the end word with a length
    // that is usually the UTF-8 byte count and sometimes arbitrary.
    task automatic send_name();
        int               n;
        int               nbytes;
        logic [CP_W-1:0]  cp;
        logic [LEN_W-1:0] len;
        n      = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
        nbytes = 0;
        for (int k = 0; k < n; k++) begin
            cp = pick_code_point();
            nbytes += (cp < 21'h80) ? 1 : (cp < 21'h800) ? 2 : (cp < 21'h10000) ? 3 : 4;
            // the length field is don't-care here; toggle it anyway
            send_word(cp, LEN_W'($urandom), 1'b0, '0);
        end
        len = ($urandom_range(0, 3) == 0) ? LEN_W'($urandom) : LEN_W'(nbytes);
        send_word('0, len, 1'b0, '0);
        names_sent++;
    endtask

    // Receiver stall pattern: a 16-bit mask rotated every cycle, reloaded
    // whenever the 6-bit tick wraps. Light level stalls about a quarter of the
    // time, heavy about three quarters.
    always @(posedge i_clk) begin
        if (!i_rst_n || stall_level == 0) begin
            i_out_stall <= 1'b0;
        end else begin
            stall_tick = stall_tick + 1'b1;
            if (stall_tick == '0) begin
                stall_pat = (stall_level == 1) ? 16'($urandom & $urandom)
                                               : 16'($urandom | $urandom);
            end
            stall_pat = {stall_pat[0], stall_pat[15:1]};
            i_out_stall <= stall_pat[0];
        end
    end

    // Scoreboard: check the outgoing word first, then fold in the incoming one,
    // so an expectation pushed at this edge is never matched at the same edge.
    always @(posedge i_clk) begin : scoreboard
        logic [HASH_W-1:0] want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                hashes_seen++;
                if (pending_hashes.size() == 0) begin
                    $display("%0t: unexpected key_hash %h with nothing pending",
                             $time, o_key_hash);
                    mismatches++;
                end else begin
                    want = pending_hashes.pop_front();
                    if (o_key_hash !== want) begin
                        $display("%0t: key_hash mismatch: expected %h, actual %h",
                                 $time, want, o_key_hash);
                        mismatches++;
                    end
                end
            end
            if (i_in_valid && !o_in_stall) begin
                words_taken++;
                if (i_code_point != '0) begin
                    name_crc = crc32c_fold(name_crc, i_code_point);
                end else begin
                    // end of name: the key, then the CRC restarts at all ones
                    pending_hashes.push_back(typed_on ? typed_hash :
                        {name_crc[HASH_BITS-1:0], LEN_W'(i_name_length + 1'b1)});
                    name_crc = CRC_INIT;
                end
            end
        end
    end

    initial begin
        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_code_point  <= '0;
        i_name_length <= '0;
        typed_on      <= 1'b0;
        typed_hash    <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table at full rate, no stalls.
        foreach (DIRECTED[r]) begin
            send_word(DIRECTED[r].cp, DIRECTED[r].len, DIRECTED[r].typed, DIRECTED[r].hash);
        end

        // Random names in phases: full rate, light idling both sides,
        // heavy receiver stalls, then everything at once.
        for (int ph = 0; ph < PHASES; ph++) begin
            sender_gaps = ph[0];
            stall_level = (ph == 0) ? 0 : (ph == 1) ? 1 : 2;
            while (words_taken < DIR_ROWS + (ph + 1) * RAND_WORDS / PHASES) begin
                send_name();
            end
        end
        i_in_valid <= 1'b0;

        // Let the scoreboard record the last word, drain, then keep watching
        // the outputs for any stray result.
        @(posedge i_clk);
        while (pending_hashes.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Covered %0d names in %0d words, %0d hashes checked,", names_sent,
                 words_taken, hashes_seen);
        $display("with sender gaps and receiver stalls at three levels.");
        if (mismatches == 0) begin
            $display("filename_hash_crc32c_top test passed");
        end else begin
            $display("filename_hash_crc32c_top test failed");
        end
        $finish;
    end

    initial begin
        #(RUN_LIMIT);
        $display("Timeout with %0d hashes still pending", pending_hashes.size());
        $display("filename_hash_crc32c_top test failed");
        $finish;
    end

endmodule
